### rtl/mtse_pkg.sv
// Shared types and constants of the multi-touch slot event encoder.
`default_nettype none

package mtse_pkg;

    // Default number of contact slots
    localparam int SLOT_COUNT_DEF = 10;
    // Most events one request may produce
    localparam int MAX_RESULTS = 32;

    // Configuration reset values
    localparam logic [15:0] AXIS_LIMIT_RST  = 16'd32767;
    localparam logic [7:0]  PRESSURE_RST    = 8'd50;
    localparam logic [15:0] TRACK_FIRST_RST = 16'd100;
    localparam logic [15:0] TRACK_LAST_RST  = 16'd60000;

    // Event types
    localparam logic [1:0] EVT_SYN = 2'd0;
    localparam logic [1:0] EVT_KEY = 2'd1;
    localparam logic [1:0] EVT_ABS = 2'd3;

    // Event codes
    localparam logic [8:0] C_SYN_REPORT = 9'h000;
    localparam logic [8:0] C_ABS_X      = 9'h000;
    localparam logic [8:0] C_ABS_Y      = 9'h001;
    localparam logic [8:0] C_MT_SLOT    = 9'h02f;
    localparam logic [8:0] C_MT_POS_X   = 9'h035;
    localparam logic [8:0] C_MT_POS_Y   = 9'h036;
    localparam logic [8:0] C_MT_TRACK   = 9'h039;
    localparam logic [8:0] C_MT_PRESS   = 9'h03a;
    localparam logic [8:0] C_BTN_TOUCH  = 9'h14a;
    localparam logic [8:0] C_BTN_FINGER = 9'h145;

    // Tracking id release value
    localparam logic [16:0] VAL_RELEASE = 17'h1ffff;

    // Command codes
    typedef enum logic [1:0] {
        MODE_DOWN   = 2'd0,
        MODE_MOVE   = 2'd1,
        MODE_UP     = 2'd2,
        MODE_CANCEL = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_AXIS_LIMIT  = 2'd0,
        REG_PRESSURE    = 2'd1,
        REG_TRACK_FIRST = 2'd2,
        REG_TRACK_LAST  = 2'd3
    } cfg_reg_t;

    // Event steps of one report sequence
    typedef enum logic [9:0] {
        ST_SLOT  = 10'b0000000001,
        ST_TRACK = 10'b0000000010,
        ST_POSX  = 10'b0000000100,
        ST_POSY  = 10'b0000001000,
        ST_PRESS = 10'b0000010000,
        ST_ABSX  = 10'b0000100000,
        ST_ABSY  = 10'b0001000000,
        ST_BTN_T = 10'b0010000000,
        ST_BTN_F = 10'b0100000000,
        ST_SYN   = 10'b1000000000
    } step_t;

    // Slot table update command
    typedef struct packed {
        logic activate;
        logic deactivate;
    } slot_cmd_t;

endpackage

`default_nettype wire

### rtl/mtse_clamp.sv
// Shared coordinate clamp unit: limits a signed coordinate to 0..limit.
`default_nettype none

module mtse_clamp (
    input  wire logic signed [16:0] raw,
    input  wire logic [15:0]        limit,
    output logic [15:0]             clamped
);

    // Negative gives zero, above limit gives limit
    always_comb
    begin
        if (raw[16])
        begin
            clamped = 16'd0;
        end
        else if (raw[15:0] > limit)
        begin
            clamped = limit;
        end
        else
        begin
            clamped = raw[15:0];
        end
    end

endmodule

`default_nettype wire

### rtl/mtse_slot_table.sv
// Per-slot contact state, tracking id counter and contact count.
`default_nettype none

module mtse_slot_table #(
    parameter int SLOT_COUNT = mtse_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mtse_pkg::slot_cmd_t cmd,
    input  wire logic [SLOT_W-1:0]   idx,
    input  wire logic [15:0]         tracking_first,
    input  wire logic [15:0]         tracking_last,
    output logic [SLOT_COUNT-1:0]    active,
    output logic [15:0]              rd_id,
    output logic [15:0]              next_id,
    output logic [3:0]               count
);

    import mtse_pkg::*;

    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [15:0]           id_reg [SLOT_COUNT];
    logic [15:0]           next_id_reg;
    logic [15:0]           next_id_next;
    logic [3:0]            count_reg;
    logic [3:0]            count_next;
    logic [16:0]           id_sum;

    assign id_sum = {1'b0, next_id_reg} + 17'd1;

    // Apply activate or release to the addressed slot
    always_comb
    begin
        active_next  = active_reg;
        next_id_next = next_id_reg;
        count_next   = count_reg;
        if (cmd.activate)
        begin
            active_next[idx] = 1'b1;
            count_next       = count_reg + 4'd1;
            if (id_sum > {1'b0, tracking_last})
            begin
                next_id_next = tracking_first;
            end
            else
            begin
                next_id_next = id_sum[15:0];
            end
        end
        else if (cmd.deactivate)
        begin
            active_next[idx] = 1'b0;
            if (count_reg != 4'd0)
            begin
                count_next = count_reg - 4'd1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            next_id_reg <= TRACK_FIRST_RST;
            count_reg   <= 4'd0;
        end
        else
        begin
            active_reg  <= active_next;
            next_id_reg <= next_id_next;
            count_reg   <= count_next;
        end
    end

    // Store the id issued to a new contact
    always_ff @(posedge clk)
    begin
        if (cmd.activate)
        begin
            id_reg[idx] <= next_id_reg;
        end
    end

    assign active  = active_reg;
    assign rd_id   = id_reg[idx];
    assign next_id = next_id_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire

### rtl/multitouch_slot_event_encoder_unit.sv
// Multi-touch slot event encoder: sequencer, output register and configuration.
// A request is clamped (X, then Y) and decoded, then its events leave
// one per cycle from the output register while out_stall is low.
// A cancel request walks the slot table in a scan state, emitting a release report
// for each active slot; no new request is taken until the sequencer is idle again.
// Reset clears active slots, contact count, output valid and sets config defaults.
`default_nettype none

module multitouch_slot_event_encoder_unit #(
    parameter int SLOT_COUNT = mtse_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [3:0]         slot,
    input  wire logic signed [16:0] x_pos,
    input  wire logic signed [16:0] y_pos,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              ev_type,
    output logic [8:0]              ev_code,
    output logic signed [16:0]      ev_value,
    output logic                    last,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    import mtse_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CLAMP_X = 6'b000010,
        S_CLAMP_Y = 6'b000100,
        S_DECIDE  = 6'b001000,
        S_SCAN    = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    // Configuration registers
    logic [15:0] axis_limit_reg;
    logic [7:0]  pressure_reg;
    logic [15:0] track_first_reg;
    logic [15:0] track_last_reg;

    // Sequencer registers
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [3:0]         slot_reg, slot_next;
    logic signed [16:0] x_reg, x_next;
    logic signed [16:0] y_reg, y_next;
    logic [15:0]        cx_reg, cx_next;
    logic [15:0]        cy_reg, cy_next;
    logic [15:0]        track_reg, track_next;
    step_t              step_reg, step_next;
    logic               prim_reg, prim_next;
    logic               btn_reg, btn_next;
    logic               lift_reg, lift_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         type_reg, type_next;
    logic [8:0]         code_reg, code_next;
    logic [16:0]        value_reg, value_next;
    logic               last_reg, last_next;

    // Slot table
    slot_cmd_t             tbl_cmd;
    logic [SLOT_W-1:0]     tbl_idx;
    logic [SLOT_COUNT-1:0] tbl_active;
    logic [15:0]           tbl_id;
    logic [15:0]           tbl_next_id;
    logic [3:0]            tbl_count;

    // Shared clamp unit
    logic signed [16:0] clamp_raw;
    logic [15:0]        clamp_out;

    // Event decode
    logic [1:0]  ev_t;
    logic [8:0]  ev_c;
    logic [16:0] ev_v;
    logic        ev_last;
    step_t       step_nx;
    logic        more_above;
    logic        dropping;
    logic        out_free;
    logic        slot_ok;
    logic        cur_active;
    logic [3:0]  cnt_inc;
    logic [3:0]  cnt_dec;
    logic        is_cancel;

    mtse_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (tbl_cmd),
        .idx            (tbl_idx),
        .tracking_first (track_first_reg),
        .tracking_last  (track_last_reg),
        .active         (tbl_active),
        .rd_id          (tbl_id),
        .next_id        (tbl_next_id),
        .count          (tbl_count)
    );

    assign clamp_raw = state_reg == S_CLAMP_X ? x_reg : y_reg;

    mtse_clamp u_clamp (
        .raw     (clamp_raw),
        .limit   (axis_limit_reg),
        .clamped (clamp_out)
    );

    assign tbl_idx    = slot_reg[SLOT_W-1:0];
    assign slot_ok    = slot_reg < 4'(SLOT_COUNT);
    assign cur_active = tbl_active[tbl_idx];
    assign cnt_inc    = tbl_count + 4'd1;
    assign cnt_dec    = (tbl_count != 4'd0) ? tbl_count - 4'd1 : tbl_count;
    assign is_cancel  = mode_reg == MODE_CANCEL;
    assign dropping   = emitted_reg == CNT_W'(MAX_RESULTS);
    assign out_free   = !out_valid_reg || !out_stall;

    // Detect active slots above the current one
    always_comb
    begin
        more_above = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (tbl_active[i] && (4'(i) > slot_reg))
            begin
                more_above = 1'b1;
            end
        end
    end

    // Decode the current step into an event and pick the following step
    always_comb
    begin
        ev_t    = EVT_ABS;
        ev_c    = C_SYN_REPORT;
        ev_v    = 17'd0;
        step_nx = ST_SYN;
        unique case (step_reg)
            ST_SLOT:
            begin
                ev_c    = C_MT_SLOT;
                ev_v    = {13'd0, slot_reg};
                step_nx = (mode_reg == MODE_MOVE) ? ST_POSX : ST_TRACK;
            end
            ST_TRACK:
            begin
                ev_c = C_MT_TRACK;
                ev_v = lift_reg ? VAL_RELEASE : {1'b0, track_reg};
                if (!lift_reg)
                begin
                    step_nx = ST_POSX;
                end
                else
                begin
                    step_nx = btn_reg ? ST_BTN_T : ST_SYN;
                end
            end
            ST_POSX:
            begin
                ev_c    = C_MT_POS_X;
                ev_v    = {1'b0, cx_reg};
                step_nx = ST_POSY;
            end
            ST_POSY:
            begin
                ev_c    = C_MT_POS_Y;
                ev_v    = {1'b0, cy_reg};
                step_nx = ST_PRESS;
            end
            ST_PRESS:
            begin
                ev_c = C_MT_PRESS;
                ev_v = {9'd0, pressure_reg};
                if (prim_reg)
                begin
                    step_nx = ST_ABSX;
                end
                else
                begin
                    step_nx = btn_reg ? ST_BTN_T : ST_SYN;
                end
            end
            ST_ABSX:
            begin
                ev_c    = C_ABS_X;
                ev_v    = {1'b0, cx_reg};
                step_nx = ST_ABSY;
            end
            ST_ABSY:
            begin
                ev_c    = C_ABS_Y;
                ev_v    = {1'b0, cy_reg};
                step_nx = btn_reg ? ST_BTN_T : ST_SYN;
            end
            ST_BTN_T:
            begin
                ev_t    = EVT_KEY;
                ev_c    = C_BTN_TOUCH;
                ev_v    = {16'd0, ~lift_reg};
                step_nx = ST_BTN_F;
            end
            ST_BTN_F:
            begin
                ev_t    = EVT_KEY;
                ev_c    = C_BTN_FINGER;
                ev_v    = {16'd0, ~lift_reg};
                step_nx = ST_SYN;
            end
            default:
            begin
                ev_t    = EVT_SYN;
                ev_c    = C_SYN_REPORT;
                ev_v    = 17'd0;
                step_nx = ST_SYN;
            end
        endcase
    end

    // Mark the final event of the request
    always_comb
    begin
        if (!is_cancel)
        begin
            ev_last = step_reg == ST_SYN;
        end
        else
        begin
            ev_last = ((step_reg == ST_SYN) && !more_above)
                   || (emitted_reg == CNT_W'(MAX_RESULTS - 1));
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        slot_next      = slot_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        track_next     = track_reg;
        step_next      = step_reg;
        prim_next      = prim_reg;
        btn_next       = btn_reg;
        lift_next      = lift_reg;
        emitted_next   = emitted_reg;
        type_next      = type_reg;
        code_next      = code_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        tbl_cmd        = '0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode_t'(mode);
                    slot_next  = slot;
                    x_next     = x_pos;
                    y_next     = y_pos;
                    state_next = S_CLAMP_X;
                end
            end
            S_CLAMP_X:
            begin
                cx_next    = clamp_out;
                state_next = S_CLAMP_Y;
            end
            S_CLAMP_Y:
            begin
                cy_next    = clamp_out;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                emitted_next = '0;
                step_next    = ST_SLOT;
                state_next   = S_IDLE;
                priority if (is_cancel)
                begin
                    slot_next  = 4'd0;
                    state_next = S_SCAN;
                end
                else if (!slot_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (mode_reg == MODE_DOWN)
                begin
                    lift_next  = 1'b0;
                    state_next = S_EMIT;
                    if (cur_active)
                    begin
                        track_next = tbl_id;
                        prim_next  = (slot_reg == 4'd0) || (tbl_count == 4'd1);
                        btn_next   = tbl_count == 4'd1;
                    end
                    else
                    begin
                        tbl_cmd.activate = 1'b1;
                        track_next       = tbl_next_id;
                        prim_next        = (slot_reg == 4'd0) || (cnt_inc == 4'd1);
                        btn_next         = cnt_inc == 4'd1;
                    end
                end
                else if (cur_active)
                begin
                    if (mode_reg == MODE_MOVE)
                    begin
                        lift_next = 1'b0;
                        prim_next = (slot_reg == 4'd0) || (tbl_count == 4'd1);
                        btn_next  = 1'b0;
                    end
                    else
                    begin
                        tbl_cmd.deactivate = 1'b1;
                        lift_next          = 1'b1;
                        prim_next          = 1'b0;
                        btn_next           = cnt_dec == 4'd0;
                    end
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                priority if (slot_reg == 4'(SLOT_COUNT))
                begin
                    state_next = S_IDLE;
                end
                else if (cur_active)
                begin
                    tbl_cmd.deactivate = 1'b1;
                    lift_next          = 1'b1;
                    prim_next          = 1'b0;
                    btn_next           = cnt_dec == 4'd0;
                    step_next          = ST_SLOT;
                    state_next         = S_EMIT;
                end
                else
                begin
                    slot_next = slot_reg + 4'd1;
                end
            end
            S_EMIT:
            begin
                // Advance when the output register frees up, or drop past the limit
                if (dropping || out_free)
                begin
                    if (!dropping)
                    begin
                        out_valid_next = 1'b1;
                        type_next      = ev_t;
                        code_next      = ev_c;
                        value_next     = ev_v;
                        last_next      = ev_last;
                        emitted_next   = emitted_reg + CNT_W'(1);
                    end
                    if (step_reg == ST_SYN)
                    begin
                        if (is_cancel)
                        begin
                            slot_next  = slot_reg + 4'd1;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        step_next = step_nx;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request and event payload
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        slot_reg    <= slot_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        track_reg   <= track_next;
        step_reg    <= step_next;
        prim_reg    <= prim_next;
        btn_reg     <= btn_next;
        lift_reg    <= lift_next;
        emitted_reg <= emitted_next;
        type_reg    <= type_next;
        code_reg    <= code_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_limit_reg  <= AXIS_LIMIT_RST;
            pressure_reg    <= PRESSURE_RST;
            track_first_reg <= TRACK_FIRST_RST;
            track_last_reg  <= TRACK_LAST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AXIS_LIMIT:  axis_limit_reg  <= cfg_data;
                REG_PRESSURE:    pressure_reg    <= cfg_data[7:0];
                REG_TRACK_FIRST: track_first_reg <= cfg_data;
                REG_TRACK_LAST:  track_last_reg  <= cfg_data;
                default:         axis_limit_reg  <= axis_limit_reg;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign ev_type   = type_reg;
    assign ev_code   = code_reg;
    assign ev_value  = value_reg;
    assign last      = last_reg;

    // Contact count tracks the number of active slots
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tbl_active) == int'(tbl_count))
        else $error("contact count does not match active slots");

    // Event counter never passes the result limit
    a_emitted_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> emitted_reg <= CNT_W'(MAX_RESULTS))
        else $error("event counter beyond result limit");

    // Slot scan runs only for a cancel request
    a_scan_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> mode_reg == MODE_CANCEL)
        else $error("slot scan outside cancel");

    // A new request, taken only with the sequencer idle, starts the clamp step
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_CLAMP_X)
        else $error("accepted request did not start clamping");

endmodule

`default_nettype wire
